@@ rtl/frgy_pkg.sv @@
// ----------------------------------------------------------------------------
// frgy_pkg: shared types and constants of the framed R/G/Y field parser
// Character codes, the token that passes from the front end to the frame
// engine, and the result word that the frame engine delivers.
// ----------------------------------------------------------------------------
package frgy_pkg;

    localparam int MAX_FRAME_BYTES = 19;
    localparam int COUNT_W         = 5;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        FIELD_NONE = 2'd0,
        FIELD_R    = 2'd1,
        FIELD_G    = 2'd2,
        FIELD_Y    = 2'd3
    } field_t;

    typedef enum logic [2:0] {
        TK_START,
        TK_END,
        TK_LETTER,
        TK_DIGIT,
        TK_OTHER
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        field_t      field;
        logic [3:0]  digit;
    } token_t;

    typedef struct packed {
        logic [7:0]  red_value;
        logic [7:0]  green_value;
        logic [7:0]  yellow_value;
        logic [15:0] starts_seen;
        logic [15:0] frames_done;
    } result_t;

endpackage

@@ rtl/framed_rgy_field_parser.sv @@
// ----------------------------------------------------------------------------
// framed_rgy_field_parser: framed R/G/Y count parser for a serial byte stream
//
// Input channel: a received word is offered on rx_byte with push; it is taken
// at a clock edge where push is high and full is low. A '$' opens a frame,
// R, G or Y selects a field, the digits after it build its value modulo 256,
// and '#' closes the frame. A frame that reaches the length limit is dropped
// but for a '#' as its last allowed byte, which closes it with zero values.
// Result channel: while empty is low the oldest frame result is on red_value,
// green_value, yellow_value, starts_seen and frames_done; it is taken at an
// edge where pop is high. Only a closing '#' inside a frame gives a result.
// Throughput is one word per cycle while the result queue has room, set by
// the frame engine, which applies one token a cycle. A '#' waits in the token
// queue, and its result is registered in the result queue for the receiver.
// Both queues hold two words. When the receiver stalls, the result queue
// fills, the frame engine halts, and full rises once the token queue fills.
// Reset clears the frame state, both counters and both queues.
// ----------------------------------------------------------------------------
module framed_rgy_field_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  red_value,
    output logic [7:0]  green_value,
    output logic [7:0]  yellow_value,
    output logic [15:0] starts_seen,
    output logic [15:0] frames_done
);

    frgy_pkg::token_t  tok;
    frgy_pkg::result_t res;
    logic              tok_valid;
    logic              tok_pop;

    frgy_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .tok_valid (tok_valid),
        .tok_pop   (tok_pop),
        .tok       (tok)
    );

    frgy_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_pop   (tok_pop),
        .tok       (tok),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign red_value    = res.red_value;
    assign green_value  = res.green_value;
    assign yellow_value = res.yellow_value;
    assign starts_seen  = res.starts_seen;
    assign frames_done  = res.frames_done;

endmodule

@@ rtl/frgy_front.sv @@
// ----------------------------------------------------------------------------
// frgy_front: byte classifier and token queue
// Decodes each accepted byte into a token and holds up to two tokens for
// the frame engine, so that the input side stalls only when both are used.
// ----------------------------------------------------------------------------
module frgy_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        rx_byte,
    output logic              tok_valid,
    input  logic              tok_pop,
    output frgy_pkg::token_t  tok
);

    frgy_pkg::token_t tok_in;
    frgy_pkg::token_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        tok_in.kind  = frgy_pkg::TK_OTHER;
        tok_in.field = frgy_pkg::FIELD_NONE;
        tok_in.digit = 4'(rx_byte - frgy_pkg::CH_ZERO);
        case (rx_byte)
            frgy_pkg::CH_START: tok_in.kind = frgy_pkg::TK_START;
            frgy_pkg::CH_END:   tok_in.kind = frgy_pkg::TK_END;
            frgy_pkg::CH_R:
            begin
                tok_in.kind  = frgy_pkg::TK_LETTER;
                tok_in.field = frgy_pkg::FIELD_R;
            end
            frgy_pkg::CH_G:
            begin
                tok_in.kind  = frgy_pkg::TK_LETTER;
                tok_in.field = frgy_pkg::FIELD_G;
            end
            frgy_pkg::CH_Y:
            begin
                tok_in.kind  = frgy_pkg::TK_LETTER;
                tok_in.field = frgy_pkg::FIELD_Y;
            end
            default:
            begin
                if (rx_byte inside {[frgy_pkg::CH_ZERO:frgy_pkg::CH_NINE]})
                begin
                    tok_in.kind = frgy_pkg::TK_DIGIT;
                end
            end
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign tok_valid = (count_reg != 2'd0);
    assign tok       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = tok_pop && tok_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= tok_in;
        end
    end

endmodule

@@ rtl/frgy_back.sv @@
// ----------------------------------------------------------------------------
// frgy_back: frame engine and result queue
// Applies one token a cycle, while the result queue has room, to the frame
// state and queues finished frames, up to two, for the result side.
// ----------------------------------------------------------------------------
module frgy_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_pop,
    input  frgy_pkg::token_t  tok,
    output logic              empty,
    input  logic              pop,
    output frgy_pkg::result_t res
);

    localparam logic [frgy_pkg::COUNT_W-1:0] MAX_COUNT =
        frgy_pkg::COUNT_W'(frgy_pkg::MAX_FRAME_BYTES);

    logic                          in_frame_reg, in_frame_next;
    logic [frgy_pkg::COUNT_W-1:0]  count_reg, count_next, count_inc;
    frgy_pkg::field_t              field_reg, field_next;
    logic [7:0]                    red_reg, red_next;
    logic [7:0]                    green_reg, green_next;
    logic [7:0]                    yellow_reg, yellow_next;
    logic [15:0]                   starts_reg, starts_next;
    logic [15:0]                   dones_reg, dones_next;
    logic                          emit;
    logic                          at_limit;
    frgy_pkg::result_t             res_in;

    frgy_pkg::result_t             slot_reg [2];
    logic                          wr_ptr_reg;
    logic                          rd_ptr_reg;
    logic [1:0]                    rcount_reg;
    logic [1:0]                    rcount_next;
    logic                          res_full;
    logic                          do_pop;

    function automatic logic [7:0] acc_step(input logic [7:0] acc, input logic [3:0] digit);
        logic [11:0] sum;
        sum = 12'(acc) * 12'd10 + 12'(digit);
        return sum[7:0];
    endfunction

    assign res_full  = (rcount_reg == 2'd2);
    assign tok_pop   = tok_valid && !res_full;
    assign count_inc = count_reg + 1'b1;
    assign at_limit  = (count_inc >= MAX_COUNT);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        field_next    = field_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        yellow_next   = yellow_reg;
        starts_next   = starts_reg;
        dones_next    = dones_reg;
        emit          = 1'b0;

        if (tok.kind == frgy_pkg::TK_START)
        begin
            starts_next   = starts_reg + 16'd1;
            in_frame_next = 1'b1;
            count_next    = frgy_pkg::COUNT_W'(1);
            field_next    = frgy_pkg::FIELD_NONE;
            red_next      = 8'd0;
            green_next    = 8'd0;
            yellow_next   = 8'd0;
        end
        else if (in_frame_reg)
        begin
            count_next = count_inc;
            case (tok.kind)
                frgy_pkg::TK_LETTER:
                begin
                    field_next = tok.field;
                    case (tok.field)
                        frgy_pkg::FIELD_R: red_next    = 8'd0;
                        frgy_pkg::FIELD_G: green_next  = 8'd0;
                        frgy_pkg::FIELD_Y: yellow_next = 8'd0;
                        default:           ;
                    endcase
                end
                frgy_pkg::TK_DIGIT:
                begin
                    case (field_reg)
                        frgy_pkg::FIELD_R: red_next    = acc_step(red_reg, tok.digit);
                        frgy_pkg::FIELD_G: green_next  = acc_step(green_reg, tok.digit);
                        frgy_pkg::FIELD_Y: yellow_next = acc_step(yellow_reg, tok.digit);
                        default:           ;
                    endcase
                end
                default: field_next = frgy_pkg::FIELD_NONE;
            endcase

            if (tok.kind == frgy_pkg::TK_END)
            begin
                dones_next    = dones_reg + 16'd1;
                emit          = 1'b1;
                in_frame_next = 1'b0;
            end
            if (at_limit)
            begin
                count_next    = '0;
                in_frame_next = 1'b0;
            end
        end
    end

    // A closing byte that is also the last allowed byte still completes
    // the frame, but its values read as zero.
    always_comb
    begin
        res_in.red_value    = at_limit ? 8'd0 : red_next;
        res_in.green_value  = at_limit ? 8'd0 : green_next;
        res_in.yellow_value = at_limit ? 8'd0 : yellow_next;
        res_in.starts_seen  = starts_next;
        res_in.frames_done  = dones_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            field_reg    <= frgy_pkg::FIELD_NONE;
            red_reg      <= 8'd0;
            green_reg    <= 8'd0;
            yellow_reg   <= 8'd0;
            starts_reg   <= 16'd0;
            dones_reg    <= 16'd0;
        end
        else if (tok_pop)
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            field_reg    <= field_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
            yellow_reg   <= yellow_next;
            starts_reg   <= starts_next;
            dones_reg    <= dones_next;
        end
    end

    assign empty  = (rcount_reg == 2'd0);
    assign res    = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        rcount_next = rcount_reg;
        if ((tok_pop && emit) && !do_pop)
        begin
            rcount_next = rcount_reg + 2'd1;
        end
        else if (do_pop && !(tok_pop && emit))
        begin
            rcount_next = rcount_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            rcount_reg <= 2'd0;
        end
        else
        begin
            if (tok_pop && emit)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            rcount_reg <= rcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && emit)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule
